>>> rtl/a64eu_pkg.sv
package a64eu_pkg;

  localparam logic [7:0]  OP_SUBS_IMM = 8'hF1;
  localparam logic [7:0]  OP_ADDS_IMM = 8'hB1;
  localparam logic [10:0] OP_SUBS_REG = 11'h758;
  localparam logic [10:0] OP_ADDS_REG = 11'h558;
  localparam logic [10:0] OP_HLT      = 11'h6A2;
  localparam logic [5:0]  OP_B        = 6'b000101;
  localparam logic [21:0] OP_BR       = 22'h3587C0;
  localparam logic [7:0]  OP_BCOND    = 8'h54;
  localparam logic [9:0]  OP_LSL      = 10'h34D;

  localparam logic [4:0]  ZERO_REG    = 5'd31;

  localparam logic [3:0]  COND_EQ     = 4'd0;
  localparam logic [3:0]  COND_NE     = 4'd1;
  localparam logic [3:0]  COND_GE     = 4'd10;
  localparam logic [3:0]  COND_LT     = 4'd11;
  localparam logic [3:0]  COND_GT     = 4'd12;
  localparam logic [3:0]  COND_LE     = 4'd13;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [63:0] val;
  } rf_wr_t;

  typedef struct packed {
    logic [63:0] next_pc;
    rf_wr_t      wr;
    logic        flag_n;
    logic        flag_z;
    logic        halt;
    logic        undef;
  } exec_res_t;

endpackage

>>> rtl/a64eu_regfile.sv
module a64eu_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [4:0]        rd_idx_a,
  input  logic [4:0]        rd_idx_b,
  output logic [63:0]       rd_data_a,
  output logic [63:0]       rd_data_b,
  input  a64eu_pkg::rf_wr_t wr
);

  logic [63:0] mem [32];
  logic [31:0] vld_r;
  logic [63:0] rdata_a_r;
  logic [63:0] rdata_b_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.val;
    end
  end

  // read at accept, forwarding the write that retires on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_idx_a == a64eu_pkg::ZERO_REG) begin
        rdata_a_r <= '0;
      end else if (wr.en && wr.idx == rd_idx_a) begin
        rdata_a_r <= wr.val;
      end else if (vld_r[rd_idx_a]) begin
        rdata_a_r <= mem[rd_idx_a];
      end else begin
        rdata_a_r <= '0;
      end
      if (rd_idx_b == a64eu_pkg::ZERO_REG) begin
        rdata_b_r <= '0;
      end else if (wr.en && wr.idx == rd_idx_b) begin
        rdata_b_r <= wr.val;
      end else if (vld_r[rd_idx_b]) begin
        rdata_b_r <= mem[rd_idx_b];
      end else begin
        rdata_b_r <= '0;
      end
    end
  end

  assign rd_data_a = rdata_a_r;
  assign rd_data_b = rdata_b_r;

endmodule

>>> rtl/a64eu_alu.sv
module a64eu_alu (
  input  logic [31:0]          instr,
  input  logic [63:0]          rn_val,
  input  logic [63:0]          rm_val,
  input  logic [63:0]          pc,
  input  logic                 flag_n,
  input  logic                 flag_z,
  input  logic                 halt,
  output a64eu_pkg::exec_res_t res
);

  logic [63:0] op2;
  logic [63:0] val;
  logic [63:0] next;
  logic [63:0] br_off26;
  logic [63:0] br_off19;
  logic        wr;
  logic        setf;
  logic        hlt;
  logic        undef;
  logic        take;

  assign br_off26 = {{36{instr[25]}}, instr[25:0], 2'b00};
  assign br_off19 = {{43{instr[23]}}, instr[23:5], 2'b00};

  always_comb begin
    unique case (instr[3:0])
      a64eu_pkg::COND_EQ: take = flag_z;
      a64eu_pkg::COND_NE: take = !flag_z;
      a64eu_pkg::COND_GE: take = !flag_n;
      a64eu_pkg::COND_LT: take = flag_n;
      a64eu_pkg::COND_GT: take = !flag_z && !flag_n;
      a64eu_pkg::COND_LE: take = flag_z || flag_n;
      default:            take = 1'b0;
    endcase
  end

  always_comb begin
    op2   = '0;
    val   = '0;
    next  = pc + 64'd4;
    wr    = 1'b0;
    setf  = 1'b0;
    hlt   = 1'b0;
    undef = 1'b0;
    priority if (instr[31:24] == a64eu_pkg::OP_SUBS_IMM ||
                 instr[31:24] == a64eu_pkg::OP_ADDS_IMM) begin
      op2  = (instr[23:22] != 2'b00) ? {40'd0, instr[21:10], 12'd0}
                                     : {52'd0, instr[21:10]};
      val  = (instr[31:24] == a64eu_pkg::OP_SUBS_IMM) ? rn_val - op2 : rn_val + op2;
      wr   = 1'b1;
      setf = 1'b1;
    end else if (instr[31:21] == a64eu_pkg::OP_SUBS_REG ||
                 instr[31:21] == a64eu_pkg::OP_ADDS_REG) begin
      op2  = rm_val << instr[15:10];
      val  = (instr[31:21] == a64eu_pkg::OP_SUBS_REG) ? rn_val - op2 : rn_val + op2;
      wr   = 1'b1;
      setf = 1'b1;
    end else if (instr[31:21] == a64eu_pkg::OP_HLT) begin
      hlt = 1'b1;
    end else if (instr[31:26] == a64eu_pkg::OP_B) begin
      next = pc + br_off26;
    end else if (instr[31:10] == a64eu_pkg::OP_BR) begin
      next = rn_val;
    end else if (instr[31:24] == a64eu_pkg::OP_BCOND) begin
      if (take) begin
        next = pc + br_off19;
      end
    end else if (instr[31:22] == a64eu_pkg::OP_LSL) begin
      // shift amount 63 - imms
      val = rn_val << (~instr[15:10]);
      wr  = 1'b1;
    end else begin
      undef = 1'b1;
      next  = pc;
    end
  end

  always_comb begin
    if (halt) begin
      res.next_pc = pc;
      res.wr      = '0;
      res.flag_n  = flag_n;
      res.flag_z  = flag_z;
      res.halt    = 1'b1;
      res.undef   = 1'b0;
    end else begin
      res.next_pc = next;
      res.wr.en   = wr && (instr[4:0] != a64eu_pkg::ZERO_REG);
      res.wr.idx  = res.wr.en ? instr[4:0] : 5'd0;
      res.wr.val  = res.wr.en ? val : 64'd0;
      res.flag_n  = setf ? val[63] : flag_n;
      res.flag_z  = setf ? (val == 64'd0) : flag_z;
      res.halt    = hlt || undef;
      res.undef   = undef;
    end
  end

endmodule

>>> rtl/arm64_subset_execute_unit.sv
// channel  | valid      | ready      | payload
// in       | in_valid   | in_ready   | in_instruction_word
// out      | out_valid  | out_ready  | out_next_pc .. out_undefined_opcode
// cfg      | cfg_valid  | cfg_ready  | cfg_start_pc (always ready)
//
// one instruction per cycle while out_ready is high; the accept edge loads the
// instruction register and reads rn/rm from the register file; the execute edge,
// once out can take it, updates pc/flags/registers and loads the result register
// a register written by one instruction reaches the next through the read bypass
// reset clears pc, flags, halt, handshake state and the 32 register valid bits
// with out_ready low one result and one instruction are held, then in_ready drops
module arm64_subset_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_next_pc,
  output logic        out_reg_write_enable,
  output logic [4:0]  out_reg_write_index,
  output logic [63:0] out_reg_write_value,
  output logic        out_negative_flag,
  output logic        out_zero_flag,
  output logic        out_halted,
  output logic        out_undefined_opcode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_start_pc
);

  logic                 in_vld_r;
  logic [31:0]          instr_r;
  logic [63:0]          pc_r;
  logic                 flag_n_r;
  logic                 flag_z_r;
  logic                 halt_r;
  logic                 out_vld_r;
  a64eu_pkg::exec_res_t res;
  a64eu_pkg::exec_res_t out_res_r;
  a64eu_pkg::rf_wr_t    rf_wr;
  logic [63:0]          rn_val;
  logic [63:0]          rm_val;
  logic                 exec_fire;
  logic                 in_fire;

  assign exec_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || exec_fire;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign rf_wr.en  = exec_fire && res.wr.en;
  assign rf_wr.idx = res.wr.idx;
  assign rf_wr.val = res.wr.val;

  a64eu_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_idx_a  (in_instruction_word[9:5]),
    .rd_idx_b  (in_instruction_word[20:16]),
    .rd_data_a (rn_val),
    .rd_data_b (rm_val),
    .wr        (rf_wr)
  );

  a64eu_alu u_alu (
    .instr  (instr_r),
    .rn_val (rn_val),
    .rm_val (rm_val),
    .pc     (pc_r),
    .flag_n (flag_n_r),
    .flag_z (flag_z_r),
    .halt   (halt_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= '0;
      flag_n_r  <= 1'b0;
      flag_z_r  <= 1'b0;
      halt_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (exec_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        pc_r <= cfg_start_pc;
      end else if (exec_fire) begin
        pc_r <= res.next_pc;
      end
      if (exec_fire) begin
        flag_n_r <= res.flag_n;
        flag_z_r <= res.flag_z;
        halt_r   <= res.halt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      instr_r <= in_instruction_word;
    end
    if (exec_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_next_pc          = out_res_r.next_pc;
  assign out_reg_write_enable = out_res_r.wr.en;
  assign out_reg_write_index  = out_res_r.wr.idx;
  assign out_reg_write_value  = out_res_r.wr.val;
  assign out_negative_flag    = out_res_r.flag_n;
  assign out_zero_flag        = out_res_r.flag_z;
  assign out_halted           = out_res_r.halt;
  assign out_undefined_opcode = out_res_r.undef;

`ifndef ASSERT_OFF
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid)
    else $error("executed transaction did not reach the result register");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt state cleared without reset");

  a_undef_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_undefined_opcode |-> out_halted)
    else $error("undefined opcode reported without halt");

  a_no_zero_reg_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.en |-> rf_wr.idx != a64eu_pkg::ZERO_REG)
    else $error("write to the zero register");

  a_halt_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && halt_r && !cfg_valid |=> $stable(pc_r))
    else $error("pc moved while halted");
`endif

endmodule
